[rtl/kls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kls_pkg: shared types and codes for the keyword lexical scanner
// Word types for both channels, scan state, token codes and the token bundle
// that goes from the scanner front end to the token back end.
// ----------------------------------------------------------------------------
package kls_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  token;
    logic [15:0] ident_number;
    logic        last_of_item;
  } out_word_t;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUMBER, M_ZERO, M_HEX, M_PLUS, M_MINUS, M_COLON,
    M_DQUOTE, M_STRING, M_QUOTE1, M_QUOTE2, M_HALTED
  } mode_t;

  typedef struct packed {
    mode_t           mode;
    logic [5:0][7:0] wbuf;
    logic [2:0]      wlen;   // 7 = longer than six characters
    logic            dot;
    logic [7:0]      held;
  } scan_t;

  typedef struct packed {
    logic [3:0][5:0] tok;
    logic [2:0]      cnt;
  } tok_list_t;

  // all tokens caused by one input word
  typedef struct packed {
    tok_list_t   list;
    logic [15:0] num;
  } bundle_t;

  localparam logic [5:0] T_TAB = 6'd0;
  localparam logic [5:0] T_CR = 6'd1;
  localparam logic [5:0] T_BKSL = 6'd2;
  localparam logic [5:0] T_DOT = 6'd3;
  localparam logic [5:0] T_ID = 6'd12;
  localparam logic [5:0] T_LPT = 6'd13;
  localparam logic [5:0] T_RPT = 6'd14;
  localparam logic [5:0] T_LCB = 6'd15;
  localparam logic [5:0] T_RCB = 6'd16;
  localparam logic [5:0] T_LSB = 6'd17;
  localparam logic [5:0] T_RSB = 6'd18;
  localparam logic [5:0] T_SEMI = 6'd19;
  localparam logic [5:0] T_PROD = 6'd20;
  localparam logic [5:0] T_DIV = 6'd21;
  localparam logic [5:0] T_REM = 6'd22;
  localparam logic [5:0] T_NL = 6'd23;
  localparam logic [5:0] T_INC = 6'd24;
  localparam logic [5:0] T_PLUS = 6'd25;
  localparam logic [5:0] T_DEC = 6'd26;
  localparam logic [5:0] T_MINUS = 6'd27;
  localparam logic [5:0] T_ASSIGN = 6'd28;
  localparam logic [5:0] T_HLIT = 6'd29;
  localparam logic [5:0] T_ILIT = 6'd30;
  localparam logic [5:0] T_RLIT = 6'd31;
  localparam logic [5:0] T_SLIT = 6'd32;
  localparam logic [5:0] T_CLIT = 6'd33;
  localparam logic [5:0] T_DOUBLEQ = 6'd34;
  localparam logic [5:0] T_SINGLEQ = 6'd35;
  localparam logic [5:0] T_ERROR = 6'd36;

endpackage
`default_nettype wire

[rtl/kls_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kls_front: character scanner
// Takes one character word, updates the scan state and builds the bundle of
// up to four tokens it causes, with the identifier number.
// ----------------------------------------------------------------------------
module kls_front #(
  parameter int IDENT_COUNT_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  kls_pkg::in_word_t in_data,
  input  wire               q_full,
  output logic              push,
  output kls_pkg::bundle_t  push_data
);
  import kls_pkg::*;

  localparam logic [7:0] C_SQ = 8'd39;
  localparam logic [7:0] C_UNDER = 8'h5F;
  localparam logic [7:0] C_X = 8'h78;
  localparam logic [7:0] C_EQ = 8'h3D;
  localparam logic [7:0] C_DQ = 8'h22;
  localparam logic [7:0] C_DOT = 8'h2E;
  localparam logic [7:0] C_PLUS = 8'h2B;
  localparam logic [7:0] C_MINUS = 8'h2D;

  scan_t st_r, st_nxt;
  logic [IDENT_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  tok_list_t lst;
  logic id_hit;
  logic acc;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_wchar(input logic [7:0] c);
    is_wchar = is_alpha(c) || is_digit(c) || c == C_UNDER;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic void emit(inout tok_list_t l, input logic [5:0] t);
    if (l.cnt < 3'd4) begin
      l.tok[l.cnt[1:0]] = t;
      l.cnt = l.cnt + 3'd1;
    end
  endfunction

  // buffer holds the first character in its low byte, unused bytes zero
  function automatic logic [5:0] kw_code(input scan_t s);
    logic [47:0] b;
    b = s.wbuf;
    kw_code = T_ID;
    if (s.wlen == 3'd2 && b == 48'h0000_0000_6669) kw_code = 6'd4;
    if (s.wlen == 3'd3 && b == 48'h0000_0072_6F66) kw_code = 6'd5;
    if (s.wlen == 3'd4 && b == 48'h0000_6573_6C65) kw_code = 6'd6;
    if (s.wlen == 3'd3 && b == 48'h0000_0074_6E69) kw_code = 6'd7;
    if (s.wlen == 3'd4 && b == 48'h0000_7261_6863) kw_code = 6'd8;
    if (s.wlen == 3'd4 && b == 48'h0000_6469_6F76) kw_code = 6'd9;
    if (s.wlen == 3'd4 && b == 48'h0000_6C61_6572) kw_code = 6'd10;
    if (s.wlen == 3'd6 && b == 48'h6E72_7574_6572) kw_code = 6'd11;
  endfunction

  function automatic void start_char(inout scan_t s, inout tok_list_t l,
                                     input logic [7:0] c);
    s.mode = M_IDLE;
    case (c)
      8'h20: ;
      8'h09: emit(l, T_TAB);
      8'h0D: emit(l, T_CR);
      8'h5C: emit(l, T_BKSL);
      C_DOT: emit(l, T_DOT);
      8'h0A: emit(l, T_NL);
      8'h28: emit(l, T_LPT);
      8'h29: emit(l, T_RPT);
      8'h7B: emit(l, T_LCB);
      8'h7D: emit(l, T_RCB);
      8'h5B: emit(l, T_LSB);
      8'h5D: emit(l, T_RSB);
      8'h3B: emit(l, T_SEMI);
      8'h2A: emit(l, T_PROD);
      8'h2F: emit(l, T_DIV);
      8'h25: emit(l, T_REM);
      C_PLUS: s.mode = M_PLUS;
      C_MINUS: s.mode = M_MINUS;
      8'h3A: s.mode = M_COLON;
      C_DQ: s.mode = M_DQUOTE;
      C_SQ: s.mode = M_QUOTE1;
      8'h30: begin
        s.mode = M_ZERO;
        s.dot = 1'b0;
      end
      default: begin
        if (is_alpha(c) || c == C_UNDER) begin
          s.wbuf = '0;
          s.wbuf[0] = c;
          s.wlen = 3'd1;
          s.mode = M_WORD;
        end else if (is_digit(c)) begin
          s.dot = 1'b0;
          s.mode = M_NUMBER;
        end else begin
          emit(l, T_ERROR);
          s.mode = M_HALTED;
        end
      end
    endcase
  endfunction

  // one character in any mode; the quote fallback is handled by the caller
  function automatic void step_base(inout scan_t s, inout tok_list_t l,
                                    input logic [7:0] c);
    logic go;
    go = 1'b1;
    case (s.mode)
      M_HALTED: go = 1'b0;
      M_WORD: begin
        if (is_wchar(c)) begin
          if (s.wlen < 3'd6) begin
            s.wbuf[s.wlen] = c;
            s.wlen = s.wlen + 3'd1;
          end else begin
            s.wlen = 3'd7;
          end
          go = 1'b0;
        end else begin
          emit(l, kw_code(s));
        end
      end
      M_ZERO: begin
        if (c == C_X) begin
          s.mode = M_HEX;
          go = 1'b0;
        end else if (is_digit(c)) begin
          s.mode = M_NUMBER;
          go = 1'b0;
        end else if (c == C_DOT) begin
          s.dot = 1'b1;
          s.mode = M_NUMBER;
          go = 1'b0;
        end else begin
          emit(l, T_ILIT);
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          go = 1'b0;
        end else if (c == C_DOT && !s.dot) begin
          s.dot = 1'b1;
          go = 1'b0;
        end else begin
          emit(l, s.dot ? T_RLIT : T_ILIT);
        end
      end
      M_HEX: begin
        if (is_hex(c)) go = 1'b0;
        else emit(l, T_HLIT);
      end
      M_PLUS: begin
        if (c == C_PLUS) begin
          emit(l, T_INC);
          s.mode = M_IDLE;
          go = 1'b0;
        end else begin
          emit(l, T_PLUS);
        end
      end
      M_MINUS: begin
        if (c == C_MINUS) begin
          emit(l, T_DEC);
          s.mode = M_IDLE;
          go = 1'b0;
        end else begin
          emit(l, T_MINUS);
        end
      end
      M_COLON: begin
        go = 1'b0;
        if (c == C_EQ) begin
          emit(l, T_ASSIGN);
          s.mode = M_IDLE;
        end else begin
          emit(l, T_ERROR);
          s.mode = M_HALTED;
        end
      end
      M_DQUOTE: begin
        if (is_wchar(c)) begin
          s.mode = M_STRING;
          go = 1'b0;
        end else begin
          emit(l, T_DOUBLEQ);
        end
      end
      M_STRING: begin
        go = 1'b0;
        if (c == C_DQ) begin
          emit(l, T_SLIT);
          s.mode = M_IDLE;
        end
      end
      M_QUOTE1: begin
        s.held = c;
        s.mode = M_QUOTE2;
        go = 1'b0;
      end
      M_QUOTE2: begin
        if (c == C_SQ) begin
          emit(l, T_CLIT);
          s.mode = M_IDLE;
          go = 1'b0;
        end
      end
      default: ;
    endcase
    if (go) start_char(s, l, c);
  endfunction

  function automatic void flush_base(inout scan_t s, inout tok_list_t l);
    case (s.mode)
      M_WORD: emit(l, kw_code(s));
      M_ZERO: emit(l, T_ILIT);
      M_NUMBER: emit(l, s.dot ? T_RLIT : T_ILIT);
      M_HEX: emit(l, T_HLIT);
      M_PLUS: emit(l, T_PLUS);
      M_MINUS: emit(l, T_MINUS);
      M_COLON: emit(l, T_ERROR);
      M_DQUOTE: emit(l, T_DOUBLEQ);
      M_STRING: emit(l, T_SLIT);
      M_QUOTE1: emit(l, T_SINGLEQ);
      default: ;
    endcase
    if (s.mode == M_COLON || s.mode == M_HALTED) s.mode = M_HALTED;
    else s.mode = M_IDLE;
  endfunction

  always_comb begin
    scan_t s;
    tok_list_t l;
    s = st_r;
    l = '0;
    if (in_data.is_end) begin
      if (s.mode == M_QUOTE2) begin
        emit(l, T_SINGLEQ);
        start_char(s, l, s.held);
      end
      flush_base(s, l);
    end else if (s.mode == M_QUOTE2 && in_data.ch != C_SQ) begin
      // bad char literal: replay the held character, then this one
      emit(l, T_SINGLEQ);
      start_char(s, l, s.held);
      step_base(s, l, in_data.ch);
    end else begin
      step_base(s, l, in_data.ch);
    end
    lst = l;
    id_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < l.cnt && l.tok[i] == T_ID) id_hit = 1'b1;
    end
    st_nxt = s;
  end

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (id_hit && cnt_r != {IDENT_COUNT_BITS{1'b1}}) cnt_nxt = cnt_r + 1'b1;
  end

  always_comb begin
    logic [IDENT_COUNT_BITS+15:0] wide;
    wide = {16'd0, cnt_nxt};
    push_data.list = lst;
    if ((wide >> 16) != '0) push_data.num = 16'hFFFF;
    else push_data.num = wide[15:0];
    push = acc && lst.cnt != 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: M_IDLE, wbuf: '0, wlen: 3'd0, dot: 1'b0, held: 8'd0};
      cnt_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/kls_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kls_queue: two-entry token bundle queue
// Decouples the scanner from the token serializer.
// ----------------------------------------------------------------------------
module kls_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  kls_pkg::bundle_t push_data,
  input  wire              pop,
  output kls_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import kls_pkg::*;

  bundle_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = cnt_r == 2'd0;
  assign full = cnt_r == 2'd2;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[rtl/kls_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kls_back: token serializer
// Sends the tokens of the head bundle one word per cycle while out_ready is high and marks the last.
// ----------------------------------------------------------------------------
module kls_back (
  input  wire                clk,
  input  wire                rst_n,
  input  kls_pkg::bundle_t   head,
  input  wire                empty,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output kls_pkg::out_word_t out_data
);
  import kls_pkg::*;

  logic [1:0] idx_r;
  logic last;

  assign last = ({1'b0, idx_r} + 3'd1) == head.list.cnt;
  assign out_valid = !empty;
  assign out_data.token = head.list.tok[idx_r];
  assign out_data.ident_number = (head.list.tok[idx_r] == T_ID) ? head.num : 16'd0;
  assign out_data.last_of_item = last;
  assign pop = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/keyword_lexical_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_lexical_scanner: streaming lexical scanner
// Characters in, token codes out; keywords, identifiers, literals, symbols.
// ----------------------------------------------------------------------------
//  channel | direction | word       | handshake
//  in_     | input     | in_word_t  | in_valid / in_ready
//  out_    | output    | out_word_t | out_valid / out_ready
//
// A character is scanned in the cycle it is accepted; its tokens (0 to 4)
// enter a two-entry queue, unless there are none, and leave one token per
// cycle at the output serializer while out_ready is high.
// Reset is synchronous; no clearing pass. in_ready drops only when the
// queue is full, so a stalled output holds two items of backlog.
// ----------------------------------------------------------------------------
module keyword_lexical_scanner #(
  parameter int IDENT_COUNT_BITS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  kls_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output kls_pkg::out_word_t out_data
);
  import kls_pkg::*;

  bundle_t push_data, head;
  logic push, pop, empty, full;

  kls_front #(.IDENT_COUNT_BITS(IDENT_COUNT_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_full(full), .push(push), .push_data(push_data)
  );

  kls_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  kls_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

[rtl/kls_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kls_checker: port-level checks for the scanner
// Watches the top-level ports and flags illegal output behavior.
// ----------------------------------------------------------------------------
module kls_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input kls_pkg::out_word_t out_data
);
  import kls_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token <= T_ERROR)
    else $error("token code out of range");

  a_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token != T_ID |-> out_data.ident_number == 16'd0)
    else $error("identifier number on non-identifier token");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind keyword_lexical_scanner kls_checker u_kls_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
`default_nettype wire

[bench/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench for keyword_lexical_scanner
// Character words go in with random gaps, token words come out under random
// stalls. A behavioral scanner predicts the tokens for every accepted word
// and a scoreboard compares them field by field, oldest first.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kls_pkg::*;

  localparam int ID_BITS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  class token_scoreboard;
    out_word_t expected_tokens[$];
    int n_mismatch;
    int n_checked;

    function void note_word(out_word_t toks[$]);
      foreach (toks[i]) expected_tokens.push_back(toks[i]);
    endfunction

    function void check_token(out_word_t got);
      out_word_t want;
      n_checked++;
      if (expected_tokens.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected token word: token=%0d num=%0d last=%0d",
                   got.token, got.ident_number, got.last_of_item);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token !== want.token || got.ident_number !== want.ident_number ||
          got.last_of_item !== want.last_of_item) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("token mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   want.token, want.ident_number, want.last_of_item,
                   got.token, got.ident_number, got.last_of_item);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;

  keyword_lexical_scanner #(.IDENT_COUNT_BITS(ID_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // ---- predictor state ----
  mode_t       sc_mode;
  logic [7:0]  sc_buf[6];
  logic [2:0]  sc_len;
  logic        sc_dot;
  logic [63:0] sc_idcount;
  logic [7:0]  sc_held;
  out_word_t   sc_toks[$];

  token_scoreboard sb;
  bit quiet_tail;
  bit hold_out;
  int n_words;
  int watchdog;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_wordch(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction
  function automatic bit is_hexch(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void push_tok(logic [5:0] t, logic [63:0] num);
    out_word_t w;
    if (sc_toks.size() >= 4) return;
    w.token = t;
    w.ident_number = (num > 64'hFFFF) ? 16'hFFFF : num[15:0];
    w.last_of_item = 1'b0;
    sc_toks.push_back(w);
  endfunction

  function automatic bit word_is(string s);
    if (sc_len != s.len()) return 0;
    for (int i = 0; i < s.len(); i++)
      if (sc_buf[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void finish_word();
    logic [63:0] lim;
    string kw[8];
    lim = (64'd1 << ID_BITS) - 1;
    kw = '{"if", "for", "else", "int", "char", "void", "real", "return"};
    for (int i = 0; i < 8; i++)
      if (word_is(kw[i])) begin
        push_tok(6'(4 + i), 0);
        return;
      end
    if (sc_idcount < lim) sc_idcount++;
    push_tok(T_ID, sc_idcount);
  endfunction

  function automatic void go_halt();
    push_tok(T_ERROR, 0);
    sc_mode = M_HALTED;
  endfunction

  function automatic void begin_char(logic [7:0] c);
    sc_mode = M_IDLE;
    case (c)
      " ": return;
      8'h09: begin push_tok(T_TAB, 0); return; end
      8'h0D: begin push_tok(T_CR, 0); return; end
      "\\": begin push_tok(T_BKSL, 0); return; end
      ".": begin push_tok(T_DOT, 0); return; end
      8'h0A: begin push_tok(T_NL, 0); return; end
      "(": begin push_tok(T_LPT, 0); return; end
      ")": begin push_tok(T_RPT, 0); return; end
      "{": begin push_tok(T_LCB, 0); return; end
      "}": begin push_tok(T_RCB, 0); return; end
      "[": begin push_tok(T_LSB, 0); return; end
      "]": begin push_tok(T_RSB, 0); return; end
      ";": begin push_tok(T_SEMI, 0); return; end
      "*": begin push_tok(T_PROD, 0); return; end
      "/": begin push_tok(T_DIV, 0); return; end
      "%": begin push_tok(T_REM, 0); return; end
      "+": begin sc_mode = M_PLUS; return; end
      "-": begin sc_mode = M_MINUS; return; end
      ":": begin sc_mode = M_COLON; return; end
      "\"": begin sc_mode = M_DQUOTE; return; end
      8'd39: begin sc_mode = M_QUOTE1; return; end
      "0": begin sc_mode = M_ZERO; sc_dot = 0; return; end
      default: ;
    endcase
    if (is_alpha(c) || c == "_") begin
      foreach (sc_buf[i]) sc_buf[i] = 0;
      sc_buf[0] = c;
      sc_len = 1;
      sc_mode = M_WORD;
    end else if (is_digit(c)) begin
      sc_dot = 0;
      sc_mode = M_NUMBER;
    end else begin
      go_halt();
    end
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [7:0] h;
    case (sc_mode)
      M_HALTED: return;
      M_WORD: begin
        if (is_wordch(c)) begin
          if (sc_len < 6) begin
            sc_buf[sc_len] = c;
            sc_len++;
          end else sc_len = 7;
          return;
        end
        finish_word();
      end
      M_ZERO: begin
        if (c == "x") begin sc_mode = M_HEX; return; end
        if (is_digit(c)) begin sc_mode = M_NUMBER; return; end
        if (c == ".") begin sc_dot = 1; sc_mode = M_NUMBER; return; end
        push_tok(T_ILIT, 0);
      end
      M_NUMBER: begin
        if (is_digit(c)) return;
        if (c == "." && !sc_dot) begin sc_dot = 1; return; end
        push_tok(sc_dot ? T_RLIT : T_ILIT, 0);
      end
      M_HEX: begin
        if (is_hexch(c)) return;
        push_tok(T_HLIT, 0);
      end
      M_PLUS: begin
        if (c == "+") begin push_tok(T_INC, 0); sc_mode = M_IDLE; return; end
        push_tok(T_PLUS, 0);
      end
      M_MINUS: begin
        if (c == "-") begin push_tok(T_DEC, 0); sc_mode = M_IDLE; return; end
        push_tok(T_MINUS, 0);
      end
      M_COLON: begin
        if (c == "=") begin push_tok(T_ASSIGN, 0); sc_mode = M_IDLE; return; end
        go_halt();
        return;
      end
      M_DQUOTE: begin
        if (is_wordch(c)) begin sc_mode = M_STRING; return; end
        push_tok(T_DOUBLEQ, 0);
      end
      M_STRING: begin
        if (c == "\"") begin push_tok(T_SLIT, 0); sc_mode = M_IDLE; end
        return;
      end
      M_QUOTE1: begin
        sc_held = c;
        sc_mode = M_QUOTE2;
        return;
      end
      M_QUOTE2: begin
        if (c == 8'd39) begin push_tok(T_CLIT, 0); sc_mode = M_IDLE; return; end
        push_tok(T_SINGLEQ, 0);
        sc_mode = M_IDLE;
        h = sc_held;
        scan_char(h);
        scan_char(c);
        return;
      end
      default: ;
    endcase
    begin_char(c);
  endfunction

  function automatic void flush_pending();
    case (sc_mode)
      M_HALTED: return;
      M_WORD: finish_word();
      M_ZERO: push_tok(T_ILIT, 0);
      M_NUMBER: push_tok(sc_dot ? T_RLIT : T_ILIT, 0);
      M_HEX: push_tok(T_HLIT, 0);
      M_PLUS: push_tok(T_PLUS, 0);
      M_MINUS: push_tok(T_MINUS, 0);
      M_COLON: begin go_halt(); return; end
      M_DQUOTE: push_tok(T_DOUBLEQ, 0);
      M_STRING: push_tok(T_SLIT, 0);
      M_QUOTE1: push_tok(T_SINGLEQ, 0);
      M_QUOTE2: begin
        push_tok(T_SINGLEQ, 0);
        sc_mode = M_IDLE;
        scan_char(sc_held);
        flush_pending();
        return;
      end
      default: ;
    endcase
    sc_mode = M_IDLE;
  endfunction

  function automatic void predict_word(in_word_t w);
    sc_toks = {};
    if (w.is_end) flush_pending();
    else scan_char(w.ch);
    if (sc_toks.size() > 0) sc_toks[sc_toks.size() - 1].last_of_item = 1'b1;
    sb.note_word(sc_toks);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sender: one word, random gap before it unless in the quiet tail
  task automatic send_word(logic [7:0] c, bit e);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{ch: c, is_end: e};
    do @(posedge clk); while (!in_ready);
    predict_word('{ch: c, is_end: e});
    n_words++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // no reset available mid-run, so errors only appear at the very end
  function automatic logic [7:0] pick_char();
    string pool;
    pool = "ifxrntu_AZaz09.+-:=\"' \t\r\n\\(){}[];*/%";
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(48, 57));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic bit safe_char(logic [7:0] c);
    mode_t m;
    logic [2:0] l;
    logic [7:0] b[6];
    logic d;
    logic [63:0] k;
    logic [7:0] hq;
    bit ok;
    out_word_t saved[$];
    m = sc_mode; l = sc_len; b = sc_buf; d = sc_dot; k = sc_idcount; hq = sc_held;
    saved = sc_toks;
    sc_toks = {};
    scan_char(c);
    ok = (sc_mode != M_HALTED);
    sc_mode = m; sc_len = l; sc_buf = b; sc_dot = d; sc_idcount = k; sc_held = hq;
    sc_toks = saved;
    return ok;
  endfunction

  task automatic send_random_text(int n);
    logic [7:0] c;
    string frags[12];
    string f;
    frags = '{"if ", "for(", "else{", "int x;", "return ", "char ", "void ",
              "real ", "0x1fA ", "3.14.5 ", "\"abc\" ", "'q' "};
    for (int i = 0; i < n;) begin
      if ($urandom_range(0, 2) == 0) begin
        f = frags[$urandom_range(0, 11)];
        for (int j = 0; j < f.len(); j++)
          if (safe_char(f[j])) begin send_word(f[j], 1'b0); i++; end
      end else begin
        c = pick_char();
        if (safe_char(c)) begin send_word(c, 1'b0); i++; end
      end
      // a pending colon would flush as an error
      if (sc_mode != M_COLON && $urandom_range(0, 15) == 0) begin
        send_end();
        i++;
      end
    end
  endtask

  // receiver
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_out = 0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
        if (out_valid && out_ready) sb.check_token(out_data);
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int settle;
    sb = new();
    watchdog = 0;
    quiet_tail = 0;
    hold_out = 0;
    n_words = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sc_mode = M_IDLE;
    foreach (sc_buf[i]) sc_buf[i] = 0;
    sc_len = 0; sc_dot = 0; sc_idcount = 0; sc_held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, long word, literals, operators, quotes
    send_text("if for else int char void real return Ifx returns abcdefgh_9");
    send_text(" 0 0x 0xfF 12.5.3 0.7 7");
    send_end();
    send_text("++ + -- - x:=y (){}[];*/%\t\r\n\\. \"s1\"\"+");
    send_end();
    send_text("'a' 'ab ''\" '");
    send_end();
    send_text("'z");
    send_end();
    send_text("\"abc");
    send_end();

    // receiver stall while sender keeps pushing
    hold_out = 1;
    send_text("a b c d e f g h i j ");
    send_random_text(50);

    quiet_tail = 1;
    send_random_text(15);
    send_end();
    // error cases close the run: lone colon, then a high byte is ignored
    send_text(":a");
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    in_valid <= 1'b0;

    settle = 0;
    while (sb.expected_tokens.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    $display("%0d character words sent, %0d token words checked, %0d bad",
             n_words, sb.n_checked, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.expected_tokens.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
